// ===== design/cmsc_pkg.sv =====
// Package for the clock mode and setting controller.
// Holds the beat layouts, mode and key codes, cursor positions and the digit helpers.
// No dependencies.
package cmsc_pkg;

	localparam int unsigned WAKE_TIMEOUT_RESET = 10;
	localparam int unsigned SECS_W             = 16;

	typedef enum logic [2:0] {
		MODE_WAKE   = 3'd0,
		MODE_SLEEP  = 3'd1,
		MODE_NORMAL = 3'd2,
		MODE_CLOSE  = 3'd3,
		MODE_MENU   = 3'd4,
		MODE_DATE   = 3'd5,
		MODE_TIME   = 3'd6
	} mode_t;

	localparam logic [1:0] FK_NORMAL = 2'd1;
	localparam logic [1:0] FK_CLOSE  = 2'd2;

	localparam logic [2:0] CK_UP    = 3'd1;
	localparam logic [2:0] CK_DOWN  = 3'd2;
	localparam logic [2:0] CK_LEFT  = 3'd3;
	localparam logic [2:0] CK_RIGHT = 3'd4;
	localparam logic [2:0] CK_OK    = 3'd5;

	localparam logic [1:0] MENU_DATE = 2'd0;
	localparam logic [1:0] MENU_TIME = 2'd1;
	localparam logic [1:0] MENU_BACK = 2'd2;

	localparam logic [2:0] DP_YEAR_TENS = 3'd0;
	localparam logic [2:0] DP_YEAR_ONES = 3'd1;
	localparam logic [2:0] DP_MONTH     = 3'd2;
	localparam logic [2:0] DP_DAY_TENS  = 3'd3;
	localparam logic [2:0] DP_DAY_ONES  = 3'd4;
	localparam logic [2:0] DP_SAVE      = 3'd5;
	localparam logic [2:0] DP_BACK      = 3'd6;

	localparam logic [2:0] TP_HOUR_TENS = 3'd0;
	localparam logic [2:0] TP_HOUR_ONES = 3'd1;
	localparam logic [2:0] TP_MIN_TENS  = 3'd2;
	localparam logic [2:0] TP_MIN_ONES  = 3'd3;
	localparam logic [2:0] TP_SEC_TENS  = 3'd4;
	localparam logic [2:0] TP_SEC_ONES  = 3'd5;
	localparam logic [2:0] TP_SAVE      = 3'd6;
	localparam logic [2:0] TP_BACK      = 3'd7;

	typedef struct packed {
		logic [5:0] cur_second;
		logic [5:0] cur_minute;
		logic [4:0] cur_hour;
		logic [4:0] cur_date;
		logic [3:0] cur_month;
		logic [6:0] cur_year;
		logic       second_tick;
		logic       presence;
		logic [2:0] ctrl_key;
		logic [1:0] front_key;
	} in_beat_t;

	typedef struct packed {
		logic [3:0] pad;
		logic       write_time;
		logic       write_date;
		logic [5:0] edit_second;
		logic [5:0] edit_minute;
		logic [4:0] edit_hour;
		logic [4:0] edit_date;
		logic [3:0] edit_month;
		logic [6:0] edit_year;
		logic [2:0] edit_cursor;
		logic [1:0] menu_cursor;
		logic       power_enable;
		logic [2:0] mode;
	} out_beat_t;

	function automatic logic [3:0] div10(input logic [6:0] v);
		logic [14:0] p;
		begin
			p = 15'(v) * 15'd205;
			return p[14:11];
		end
	endfunction

	function automatic logic [6:0] mod10(input logic [6:0] v);
		return v - 7'(div10(v) * 7'd10);
	endfunction

	function automatic logic [6:0] tens_up(input logic [6:0] v, input logic [3:0] top);
		return (div10(v) == top) ? mod10(v) : v + 7'd10;
	endfunction

	function automatic logic [6:0] tens_down(input logic [6:0] v, input logic [3:0] top);
		return (div10(v) == 4'd0) ? v + 7'(top * 7'd10) : v - 7'd10;
	endfunction

	function automatic logic [6:0] ones_up(input logic [6:0] v);
		return (mod10(v) == 7'd9) ? v - 7'd9 : v + 7'd1;
	endfunction

	function automatic logic [6:0] ones_down(input logic [6:0] v);
		return (mod10(v) == 7'd0) ? v + 7'd9 : v - 7'd1;
	endfunction

	function automatic logic [6:0] cap(input logic [6:0] v, input logic [6:0] hi);
		return (v > hi) ? hi : v;
	endfunction

endpackage

// ===== design/clock_mode_and_setting_controller.sv =====
// Top level of the clock mode and setting controller: mode machine, menu and editors.
// Depends on cmsc_pkg.
//
//  channel   | direction | beat contents
//  s_axis    | in        | one control pass: keys, presence, tick, clock time
//  m_axis    | out       | one result: mode, power, cursors, edit buffers, write pulses
//  cfg       | in        | wake timeout in seconds, 16 bits
//
// One beat a cycle while the output is not stalled: input register, one pass of update logic, result register.
// An input beat is held in the input register, and its result then in the result register.
// A stalled output holds the result; the input register still refills when the result
// register drains in the same cycle. Reset clears mode, counters, cursors and load flags.
module clock_mode_and_setting_controller
	import cmsc_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	// front_key[1:0] ctrl_key[4:2] presence[5] second_tick[6] cur_year[13:7]
	// cur_month[17:14] cur_date[22:18] cur_hour[27:23] cur_minute[33:28] cur_second[39:34]
	input  logic [39:0] s_axis_tdata,
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	// mode[2:0] power_enable[3] menu_cursor[5:4] edit_cursor[8:6] edit_year[15:9]
	// edit_month[19:16] edit_date[24:20] edit_hour[29:25] edit_minute[35:30]
	// edit_second[41:36] write_date[42] write_time[43] zero[47:44]
	output logic [47:0] m_axis_tdata,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [15:0] cfg_data
);

	logic              valid_s1;
	in_beat_t          beat_s1;
	logic              out_valid_q;
	out_beat_t         out_q;
	logic              advance;

	logic [SECS_W-1:0] timeout_q;
	mode_t             mode_q;
	logic [SECS_W-1:0] secs_q;
	logic [1:0]        menu_q;
	logic [2:0]        dpos_q;
	logic [2:0]        tpos_q;
	logic              dload_q;
	logic              tload_q;
	logic [6:0]        year_q;
	logic [3:0]        month_q;
	logic [4:0]        day_q;
	logic [4:0]        hour_q;
	logic [5:0]        min_q;
	logic [5:0]        sec_q;

	mode_t             mode_n;
	logic [SECS_W-1:0] secs_n;
	logic [1:0]        menu_n;
	logic [2:0]        dpos_n;
	logic [2:0]        tpos_n;
	logic              dload_n;
	logic              tload_n;
	logic [6:0]        year_w;
	logic [3:0]        month_w;
	logic [6:0]        day_w;
	logic [6:0]        hour_w;
	logic [6:0]        min_w;
	logic [6:0]        sec_w;
	logic              wd;
	logic              wt;
	out_beat_t         res;

	assign advance       = valid_s1 && (!out_valid_q || m_axis_tready);
	assign s_axis_tready = !valid_s1 || advance;
	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_q;
	assign cfg_ready     = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (s_axis_tready)
				valid_s1 <= s_axis_tvalid;
			if (advance)
				out_valid_q <= 1'b1;
			else if (m_axis_tready)
				out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid)
			beat_s1 <= s_axis_tdata;
		if (advance)
			out_q <= res;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			timeout_q <= SECS_W'(WAKE_TIMEOUT_RESET);
			mode_q    <= MODE_WAKE;
			secs_q    <= '0;
			menu_q    <= '0;
			dpos_q    <= '0;
			tpos_q    <= '0;
			dload_q   <= 1'b0;
			tload_q   <= 1'b0;
		end else begin
			if (cfg_valid)
				timeout_q <= cfg_data;
			if (advance) begin
				mode_q  <= mode_n;
				secs_q  <= secs_n;
				menu_q  <= menu_n;
				dpos_q  <= dpos_n;
				tpos_q  <= tpos_n;
				dload_q <= dload_n;
				tload_q <= tload_n;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance && mode_q == MODE_DATE) begin
			year_q  <= year_w;
			month_q <= month_w;
			day_q   <= day_w[4:0];
		end
		if (advance && mode_q == MODE_TIME) begin
			hour_q <= hour_w[4:0];
			min_q  <= min_w[5:0];
			sec_q  <= sec_w[5:0];
		end
	end

	always_comb begin
		mode_n  = mode_q;
		secs_n  = (beat_s1.second_tick && secs_q != '1) ? secs_q + 1'b1 : secs_q;
		menu_n  = menu_q;
		dpos_n  = dpos_q;
		tpos_n  = tpos_q;
		dload_n = dload_q;
		tload_n = tload_q;
		wd      = 1'b0;
		wt      = 1'b0;

		if (dload_q) begin
			year_w  = year_q;
			month_w = month_q;
			day_w   = {2'b00, day_q};
		end else begin
			year_w  = cap(beat_s1.cur_year, 7'd99);
			month_w = (beat_s1.cur_month == 4'd0) ? 4'd1 :
				(beat_s1.cur_month > 4'd12) ? 4'd12 : beat_s1.cur_month;
			day_w   = {2'b00, beat_s1.cur_date};
		end
		if (tload_q) begin
			hour_w = {2'b00, hour_q};
			min_w  = {1'b0, min_q};
			sec_w  = {1'b0, sec_q};
		end else begin
			hour_w = cap({2'b00, beat_s1.cur_hour}, 7'd23);
			min_w  = cap({1'b0, beat_s1.cur_minute}, 7'd59);
			sec_w  = cap({1'b0, beat_s1.cur_second}, 7'd59);
		end

		case (mode_q)
			MODE_WAKE, MODE_SLEEP, MODE_NORMAL, MODE_CLOSE: begin
				if (mode_q == MODE_WAKE || mode_q == MODE_SLEEP) begin
					if (mode_q != MODE_WAKE)
						secs_n = '0;
					else if (secs_n > timeout_q)
						mode_n = MODE_SLEEP;
					if (beat_s1.presence) begin
						mode_n = MODE_WAKE;
						secs_n = '0;
					end
				end
				if (beat_s1.front_key == FK_NORMAL)
					mode_n = (mode_n == MODE_NORMAL) ? MODE_WAKE : MODE_NORMAL;
				else if (beat_s1.front_key == FK_CLOSE)
					mode_n = (mode_n == MODE_CLOSE) ? MODE_WAKE : MODE_CLOSE;
				if (beat_s1.ctrl_key == CK_OK)
					mode_n = MODE_MENU;
			end
			MODE_MENU: begin
				case (beat_s1.ctrl_key)
					CK_UP, CK_LEFT:
						menu_n = (menu_q > 2'd0) ? menu_q - 2'd1 : MENU_BACK;
					CK_DOWN, CK_RIGHT:
						menu_n = (menu_q < MENU_BACK) ? menu_q + 2'd1 : MENU_DATE;
					CK_OK: begin
						case (menu_q)
							MENU_DATE: mode_n = MODE_DATE;
							MENU_TIME: mode_n = MODE_TIME;
							MENU_BACK: mode_n = MODE_WAKE;
							default:   mode_n = mode_q;
						endcase
						menu_n = MENU_DATE;
					end
					default: menu_n = menu_q;
				endcase
			end
			MODE_DATE: begin
				dload_n = 1'b1;
				case (beat_s1.ctrl_key)
					CK_UP: begin
						case (dpos_q)
							DP_YEAR_TENS: year_w = tens_up(year_w, 4'd9);
							DP_YEAR_ONES: year_w = ones_up(year_w);
							DP_MONTH:     month_w = (month_w < 4'd12) ? month_w + 4'd1 : 4'd1;
							DP_DAY_TENS:  day_w = tens_up(day_w, 4'd3);
							DP_DAY_ONES:  day_w = ones_up(day_w);
							default:      day_w = day_w;
						endcase
					end
					CK_DOWN: begin
						case (dpos_q)
							DP_YEAR_TENS: year_w = tens_down(year_w, 4'd9);
							DP_YEAR_ONES: year_w = ones_down(year_w);
							DP_MONTH:     month_w = (month_w > 4'd1) ? month_w - 4'd1 : 4'd12;
							DP_DAY_TENS:  day_w = tens_down(day_w, 4'd3);
							DP_DAY_ONES:  day_w = ones_down(day_w);
							default:      day_w = day_w;
						endcase
					end
					CK_LEFT:
						dpos_n = (dpos_q == 3'd0) ? DP_BACK :
							(dpos_q > DP_BACK) ? DP_BACK : dpos_q - 3'd1;
					CK_RIGHT:
						dpos_n = (dpos_q < DP_BACK) ? dpos_q + 3'd1 : 3'd0;
					CK_OK: begin
						if (dpos_q == DP_SAVE) begin
							wd      = 1'b1;
							mode_n  = MODE_WAKE;
							dload_n = 1'b0;
						end else if (dpos_q == DP_BACK) begin
							mode_n  = MODE_MENU;
							dload_n = 1'b0;
						end
						dpos_n = 3'd0;
					end
					default: dpos_n = dpos_q;
				endcase
				year_w = cap(year_w, 7'd99);
				day_w  = cap(day_w, 7'd31);
				if (month_w == 4'd2)
					day_w = cap(day_w, 7'd29);
				if (month_w == 4'd4 || month_w == 4'd6 || month_w == 4'd9 || month_w == 4'd11)
					day_w = cap(day_w, 7'd30);
			end
			MODE_TIME: begin
				tload_n = 1'b1;
				case (beat_s1.ctrl_key)
					CK_UP: begin
						case (tpos_q)
							TP_HOUR_TENS: hour_w = tens_up(hour_w, 4'd2);
							TP_HOUR_ONES: hour_w = ones_up(hour_w);
							TP_MIN_TENS:  min_w = tens_up(min_w, 4'd5);
							TP_MIN_ONES:  min_w = ones_up(min_w);
							TP_SEC_TENS:  sec_w = tens_up(sec_w, 4'd5);
							TP_SEC_ONES:  sec_w = ones_up(sec_w);
							default:      sec_w = sec_w;
						endcase
					end
					CK_DOWN: begin
						case (tpos_q)
							TP_HOUR_TENS: hour_w = tens_down(hour_w, 4'd2);
							TP_HOUR_ONES: hour_w = ones_down(hour_w);
							TP_MIN_TENS:  min_w = tens_down(min_w, 4'd5);
							TP_MIN_ONES:  min_w = ones_down(min_w);
							TP_SEC_TENS:  sec_w = tens_down(sec_w, 4'd5);
							TP_SEC_ONES:  sec_w = ones_down(sec_w);
							default:      sec_w = sec_w;
						endcase
					end
					CK_LEFT:  tpos_n = tpos_q - 3'd1;
					CK_RIGHT: tpos_n = tpos_q + 3'd1;
					CK_OK: begin
						if (tpos_q == TP_SAVE) begin
							wt      = 1'b1;
							mode_n  = MODE_WAKE;
							tload_n = 1'b0;
						end else if (tpos_q == TP_BACK) begin
							mode_n  = MODE_MENU;
							tload_n = 1'b0;
						end
						tpos_n = 3'd0;
					end
					default: tpos_n = tpos_q;
				endcase
				hour_w = cap(hour_w, 7'd23);
				min_w  = cap(min_w, 7'd59);
				sec_w  = cap(sec_w, 7'd59);
			end
			default: mode_n = MODE_WAKE;
		endcase

		res              = '0;
		res.mode         = mode_n;
		res.power_enable = (mode_n == MODE_WAKE || mode_n == MODE_NORMAL);
		res.menu_cursor  = menu_n;
		res.write_date   = wd;
		res.write_time   = wt;
		if (mode_q == MODE_DATE) begin
			res.edit_cursor = dpos_n;
			res.edit_year   = year_w;
			res.edit_month  = month_w;
			res.edit_date   = day_w[4:0];
		end else if (mode_q == MODE_TIME) begin
			res.edit_cursor = tpos_n;
			res.edit_hour   = hour_w[4:0];
			res.edit_minute = min_w[5:0];
			res.edit_second = sec_w[5:0];
		end
	end

endmodule
